@@ src/btdc_pkg.sv @@
package btdc_pkg;

    localparam int ADDR_W        = 16;
    localparam int STORE_DEPTH   = 2 ** ADDR_W;
    localparam int TEMPLATE_W    = 10;
    localparam int COLOR_W       = 8;
    localparam int THRESH_W      = 10;
    localparam int CLASS_COUNT   = 10;
    localparam int CLASS_W       = 4;
    localparam int COUNT_W       = 17;
    localparam int FRAME_PIXELS  = 65536;
    localparam int COUNT_MAX     = 131071;
    localparam int COUNT_LIMIT   = (FRAME_PIXELS > COUNT_MAX) ? COUNT_MAX : FRAME_PIXELS;

    localparam logic [THRESH_W-1:0] THRESH_RESET = THRESH_W'(500);

    // Request kinds.
    localparam logic KIND_LOAD     = 1'b0;
    localparam logic KIND_CLASSIFY = 1'b1;

    // Reduction tree widths; four pairwise levels cover up to sixteen classes.
    localparam int L1_N = (CLASS_COUNT + 1) / 2;
    localparam int L2_N = (L1_N + 1) / 2;
    localparam int L3_N = (L2_N + 1) / 2;
    localparam int L4_N = (L3_N + 1) / 2;

    typedef logic [CLASS_COUNT-1:0][COUNT_W-1:0] count_vec_t;

    // Counter snapshot handed from the match stage to the minimum search.
    typedef struct packed {
        logic       valid;
        count_vec_t counts;
    } snap_t;

    typedef struct packed {
        logic [CLASS_W-1:0] idx;
        logic [COUNT_W-1:0] cnt;
    } cand_t;

    // The left operand always holds the lower class index, so a tie keeps it.
    function automatic cand_t pick_min(input cand_t a, input cand_t b);
        cand_t r;
        if (b.cnt < a.cnt) begin
            r = b;
        end else begin
            r = a;
        end
        return r;
    endfunction

endpackage

@@ src/btdc_in_if.sv @@
interface btdc_in_if;
    logic                               valid;
    logic                               ready;
    logic                               kind;
    logic [btdc_pkg::ADDR_W-1:0]        pixel_address;
    logic [btdc_pkg::TEMPLATE_W-1:0]    template_bits;
    logic [btdc_pkg::COLOR_W-1:0]       red;
    logic [btdc_pkg::COLOR_W-1:0]       green;
    logic [btdc_pkg::COLOR_W-1:0]       blue;
    logic                               last_pixel;

    modport source (
        output valid, kind, pixel_address, template_bits, red, green, blue, last_pixel,
        input  ready
    );

    modport sink (
        input  valid, kind, pixel_address, template_bits, red, green, blue, last_pixel,
        output ready
    );
endinterface

@@ src/btdc_out_if.sv @@
interface btdc_out_if;
    logic                           valid;
    logic                           ready;
    logic [btdc_pkg::CLASS_W-1:0]   best_class;
    logic [btdc_pkg::COUNT_W-1:0]   mismatch_count;

    modport source (
        output valid, best_class, mismatch_count,
        input  ready
    );

    modport sink (
        input  valid, best_class, mismatch_count,
        output ready
    );
endinterface

@@ src/btdc_match_stage.sv @@
// Template store, pixel thresholding and the per-class mismatch counters.
module btdc_match_stage (
    input  logic                            clk,
    input  logic                            rst_n,
    btdc_in_if.sink                         pixel,
    input  logic [btdc_pkg::THRESH_W-1:0]   white_threshold,
    output btdc_pkg::snap_t                 snap,
    input  logic                            snap_ready
);

    logic [btdc_pkg::TEMPLATE_W-1:0] store_mem [btdc_pkg::STORE_DEPTH];
    logic [btdc_pkg::TEMPLATE_W-1:0] rdata_reg;

    logic                            v1_reg;
    logic                            white1_reg;
    logic                            last1_reg;
    btdc_pkg::count_vec_t            cnt_reg;
    btdc_pkg::count_vec_t            cnt_next;
    logic                            snap_valid_reg;
    btdc_pkg::count_vec_t            snap_counts_reg;

    logic                            accept;
    logic                            s1_ready;
    logic                            s1_done;
    logic [btdc_pkg::THRESH_W-1:0]   rgb_sum;
    logic                            white0;
    logic [btdc_pkg::CLASS_COUNT-1:0] tword;

    assign s1_ready    = !v1_reg || !last1_reg || snap_ready;
    assign pixel.ready = s1_ready;
    assign accept      = pixel.valid && s1_ready;
    assign s1_done     = v1_reg && s1_ready;

    assign rgb_sum = btdc_pkg::THRESH_W'(pixel.red) + btdc_pkg::THRESH_W'(pixel.green)
                   + btdc_pkg::THRESH_W'(pixel.blue);
    assign white0  = rgb_sum >= white_threshold;

    // Loads write the store; classify requests read it. Only one request is
    // taken per cycle, so a read always sees every earlier write.
    always_ff @(posedge clk)
    begin
        if (accept && pixel.kind == btdc_pkg::KIND_LOAD)
        begin
            store_mem[pixel.pixel_address] <= pixel.template_bits;
        end
        if (accept && pixel.kind == btdc_pkg::KIND_CLASSIFY)
        begin
            rdata_reg <= store_mem[pixel.pixel_address];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            white1_reg <= white0;
            last1_reg  <= pixel.last_pixel;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (s1_ready)
        begin
            v1_reg <= accept && pixel.kind == btdc_pkg::KIND_CLASSIFY;
        end
    end

    // Classes beyond the template word read as black.
    assign tword = btdc_pkg::CLASS_COUNT'(rdata_reg);

    always_comb
    begin
        for (int c = 0; c < btdc_pkg::CLASS_COUNT; c++)
        begin
            if ((tword[c] != white1_reg)
                && (cnt_reg[c] < btdc_pkg::COUNT_W'(btdc_pkg::COUNT_LIMIT)))
            begin
                cnt_next[c] = cnt_reg[c] + btdc_pkg::COUNT_W'(1);
            end
            else
            begin
                cnt_next[c] = cnt_reg[c];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (s1_done)
        begin
            if (last1_reg)
            begin
                cnt_reg <= '0;
            end
            else
            begin
                cnt_reg <= cnt_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            snap_valid_reg <= 1'b0;
        end
        else if (snap_ready)
        begin
            snap_valid_reg <= s1_done && last1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_done && last1_reg)
        begin
            snap_counts_reg <= cnt_next;
        end
    end

    assign snap = {snap_valid_reg, snap_counts_reg};

endmodule

@@ src/btdc_min_tree.sv @@
// Registered minimum search over the counter snapshot, lowest index on ties.
module btdc_min_tree (
    input  logic                clk,
    input  logic                rst_n,
    input  btdc_pkg::snap_t     snap,
    output logic                snap_ready,
    btdc_out_if.source          result
);

    btdc_pkg::cand_t leaf   [btdc_pkg::CLASS_COUNT];
    btdc_pkg::cand_t lvl1   [btdc_pkg::L1_N];
    btdc_pkg::cand_t lvl2   [btdc_pkg::L2_N];
    btdc_pkg::cand_t s3_reg [btdc_pkg::L2_N];
    btdc_pkg::cand_t lvl3   [btdc_pkg::L3_N];
    btdc_pkg::cand_t lvl4   [btdc_pkg::L4_N];

    logic                           v3_reg;
    logic                           vout_reg;
    logic [btdc_pkg::CLASS_W-1:0]   best_reg;
    logic [btdc_pkg::COUNT_W-1:0]   count_reg;
    logic                           out_free;
    logic                           s3_ready;

    assign out_free   = !vout_reg || result.ready;
    assign s3_ready   = !v3_reg || out_free;
    assign snap_ready = !snap.valid || s3_ready;

    // First two levels of pairwise compares, ahead of the middle register.
    always_comb begin
        for (int i = 0; i < btdc_pkg::CLASS_COUNT; i++) begin
            leaf[i].idx = btdc_pkg::CLASS_W'(i);
            leaf[i].cnt = snap.counts[i];
        end
        for (int i = 0; i < btdc_pkg::L1_N; i++) begin
            if (2 * i + 1 < btdc_pkg::CLASS_COUNT) begin
                lvl1[i] = btdc_pkg::pick_min(leaf[2*i], leaf[2*i+1]);
            end else begin
                lvl1[i] = leaf[2*i];
            end
        end
        for (int i = 0; i < btdc_pkg::L2_N; i++) begin
            if (2 * i + 1 < btdc_pkg::L1_N) begin
                lvl2[i] = btdc_pkg::pick_min(lvl1[2*i], lvl1[2*i+1]);
            end else begin
                lvl2[i] = lvl1[2*i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            v3_reg <= 1'b0;
        end else if (s3_ready) begin
            v3_reg <= snap.valid;
        end
    end

    always_ff @(posedge clk) begin
        if (s3_ready && snap.valid) begin
            s3_reg <= lvl2;
        end
    end

    // Remaining levels, down to a single winner.
    always_comb begin
        for (int i = 0; i < btdc_pkg::L3_N; i++) begin
            if (2 * i + 1 < btdc_pkg::L2_N) begin
                lvl3[i] = btdc_pkg::pick_min(s3_reg[2*i], s3_reg[2*i+1]);
            end else begin
                lvl3[i] = s3_reg[2*i];
            end
        end
        for (int i = 0; i < btdc_pkg::L4_N; i++) begin
            if (2 * i + 1 < btdc_pkg::L3_N) begin
                lvl4[i] = btdc_pkg::pick_min(lvl3[2*i], lvl3[2*i+1]);
            end else begin
                lvl4[i] = lvl3[2*i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            vout_reg <= 1'b0;
        end else if (out_free) begin
            vout_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk) begin
        if (out_free && v3_reg) begin
            best_reg  <= lvl4[0].idx;
            count_reg <= lvl4[0].cnt;
        end
    end

    assign result.valid          = vout_reg;
    assign result.best_class     = best_reg;
    assign result.mismatch_count = count_reg;

endmodule

@@ src/binary_template_digit_classifier_unit.sv @@
// Channel   Dir  Role      Payload
// pixel     in   sink      kind, pixel_address, template_bits, red, green, blue, last_pixel
// result    out  source    best_class, mismatch_count
// config    in   write     white_threshold_we, white_threshold_wdata (10 bits)
//
// One request is taken every cycle unless a last pixel waits on a full result
// path; the rate is set by the single-port template memory, which is either
// written (load) or read (classify) once per request. A frame result passes
// through the memory read, the counter update into the snapshot, the first two
// levels of the minimum tree, then the last two into the output register.
// Reset clears the counters, the pipeline valid flags and sets the threshold to
// 500; the template memory keeps its contents and has no clearing pass.
// A stalled result backs up only the result path; up to three finished frames
// can wait before a last pixel holds the input.
module binary_template_digit_classifier_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    btdc_in_if.sink                         pixel,
    btdc_out_if.source                      result,
    input  logic                            white_threshold_we,
    input  logic [btdc_pkg::THRESH_W-1:0]   white_threshold_wdata
);

    logic [btdc_pkg::THRESH_W-1:0] thresh_reg;
    btdc_pkg::snap_t               snap;
    logic                          snap_ready;

    // The threshold register must be written by the user only while the block is
    // idle, so requests in flight never see it change; the block does not enforce it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg <= btdc_pkg::THRESH_RESET;
        end
        else if (white_threshold_we)
        begin
            thresh_reg <= white_threshold_wdata;
        end
    end

    // Store access and per-class mismatch counting; a last pixel hands the
    // updated counts over as a snapshot and clears the counters.
    btdc_match_stage u_match (
        .clk             (clk),
        .rst_n           (rst_n),
        .pixel           (pixel),
        .white_threshold (thresh_reg),
        .snap            (snap),
        .snap_ready      (snap_ready)
    );

    // Minimum search over the snapshot and the output register.
    btdc_min_tree u_min (
        .clk        (clk),
        .rst_n      (rst_n),
        .snap       (snap),
        .snap_ready (snap_ready),
        .result     (result)
    );

endmodule

@@ bench/binary_template_digit_classifier_unit_test.sv @@
module binary_template_digit_classifier_unit_test;

    timeunit 1ns;
    timeprecision 1ps;

    import btdc_pkg::*;

    // A run this short never needs more than a fraction of this many cycles,
    // even when every request and every result waits out the longest gap.
    localparam int CYCLE_LIMIT   = 500000;
    localparam int SETTLE_CYCLES = 8;
    localparam int REPORT_LIMIT  = 10;
    localparam int PHASE_REQUESTS = 205;

    // One pixel channel request, as the driver and the predictor see it.
    typedef struct {
        logic                  kind;
        logic [ADDR_W-1:0]     addr;
        logic [TEMPLATE_W-1:0] bits;
        logic [COLOR_W-1:0]    red;
        logic [COLOR_W-1:0]    green;
        logic [COLOR_W-1:0]    blue;
        logic                  last;
    } pixel_req_t;

    // The verdict that closes one frame.
    typedef struct {
        logic [CLASS_W-1:0] best_class;
        logic [COUNT_W-1:0] mismatch_count;
    } verdict_t;

    // The scoreboard keeps its own copy of the template memory, the per-class
    // mismatch tallies and the threshold. Each accepted classify request
    // updates the tallies; a last pixel turns them into an expected verdict.
    class digit_score_keeper;
        logic [TEMPLATE_W-1:0] template_mem [bit [ADDR_W-1:0]];
        logic [COUNT_W-1:0]    tallies [CLASS_COUNT];
        logic [THRESH_W-1:0]   threshold;
        verdict_t              pending_verdicts [$];
        int                    failures;
        int                    verdicts_seen;

        function new();
            threshold = THRESH_RESET;
            failures = 0;
            verdicts_seen = 0;
            foreach (tallies[c])
                tallies[c] = '0;
        endfunction

        function void note_request(pixel_req_t r);
            logic [9:0]            rgb_sum;
            logic                  white;
            logic                  tbit;
            logic [TEMPLATE_W-1:0] word;
            verdict_t              v;
            if (r.kind == KIND_LOAD)
            begin
                template_mem[r.addr] = r.bits;
                return;
            end
            rgb_sum = 10'(r.red) + 10'(r.green) + 10'(r.blue);
            white = (rgb_sum >= threshold);
            word = template_mem.exists(r.addr) ? template_mem[r.addr] : '0;
            for (int c = 0; c < CLASS_COUNT; c++)
            begin
                tbit = (c < TEMPLATE_W) ? word[c] : 1'b0;
                if (tbit != white && tallies[c] < COUNT_LIMIT)
                    tallies[c] = tallies[c] + 1'b1;
            end
            if (!r.last)
                return;
            v.best_class = '0;
            v.mismatch_count = tallies[0];
            for (int c = 1; c < CLASS_COUNT; c++)
            begin
                if (tallies[c] < v.mismatch_count)
                begin
                    v.best_class = CLASS_W'(c);
                    v.mismatch_count = tallies[c];
                end
            end
            foreach (tallies[c])
                tallies[c] = '0;
            pending_verdicts.push_back(v);
        endfunction

        function void check_result(logic [CLASS_W-1:0] got_class,
                                   logic [COUNT_W-1:0] got_count);
            verdict_t v;
            verdicts_seen++;
            if (pending_verdicts.size() == 0)
            begin
                if (failures < REPORT_LIMIT)
                    $display("[%0t] verdict %0d arrived with none pending: class %0d count %0d",
                             $realtime, verdicts_seen, got_class, got_count);
                failures++;
                return;
            end
            v = pending_verdicts.pop_front();
            if (got_class !== v.best_class || got_count !== v.mismatch_count)
            begin
                if (failures < REPORT_LIMIT)
                    $display("[%0t] verdict %0d: expected class %0d count %0d, got class %0d count %0d",
                             $realtime, verdicts_seen, v.best_class, v.mismatch_count,
                             got_class, got_count);
                failures++;
            end
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                thresh_we;
    logic [THRESH_W-1:0] thresh_wdata;

    btdc_in_if  pixel_ch ();
    btdc_out_if result_ch ();

    binary_template_digit_classifier_unit DUT (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .pixel                 (pixel_ch),
        .result                (result_ch),
        .white_threshold_we    (thresh_we),
        .white_threshold_wdata (thresh_wdata)
    );

    digit_score_keeper keeper = new();

    // Addresses whose template word has been loaded. Classify requests only
    // ever point here, since an unloaded word has no defined contents.
    logic [ADDR_W-1:0] loaded_addrs [$];

    // When clear, neither side inserts gaps, so long back-to-back stretches
    // run at the full rate of one request per cycle.
    bit pacing_on;
    int requests_sent;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    // Template words lean toward all black and all white so that ties and
    // clean wins both come up often.
    function automatic logic [TEMPLATE_W-1:0] pick_word();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 15)
            return '0;
        if (roll < 30)
            return '1;
        return TEMPLATE_W'($urandom);
    endfunction

    // Colors are uniform, saturated, or split from a sum that sits one below,
    // at or one above the current threshold.
    function automatic void pick_color(input logic [THRESH_W-1:0] thr,
                                       output logic [COLOR_W-1:0] r,
                                       output logic [COLOR_W-1:0] g,
                                       output logic [COLOR_W-1:0] b);
        int roll;
        int target;
        int rest;
        int lo;
        int hi;
        roll = $urandom_range(0, 99);
        if (roll < 40)
        begin
            r = COLOR_W'($urandom);
            g = COLOR_W'($urandom);
            b = COLOR_W'($urandom);
        end
        else if (roll < 60)
        begin
            r = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            g = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            b = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        end
        else
        begin
            target = int'(thr) + $urandom_range(0, 2) - 1;
            if (target < 0)
                target = 0;
            if (target > 765)
                target = 765;
            lo = (target > 510) ? target - 510 : 0;
            hi = (target < 255) ? target : 255;
            r = COLOR_W'($urandom_range(lo, hi));
            rest = target - int'(r);
            lo = (rest > 255) ? rest - 255 : 0;
            hi = (rest < 255) ? rest : 255;
            g = COLOR_W'($urandom_range(lo, hi));
            b = COLOR_W'(rest - int'(g));
        end
    endfunction

    // Drives one request at the falling edge and holds it until the block
    // takes it. A zero gap leaves valid high so the next request follows in
    // the very next cycle.
    task automatic issue_request(input pixel_req_t r);
        int gap;
        @(negedge clk);
        pixel_ch.valid         <= 1'b1;
        pixel_ch.kind          <= r.kind;
        pixel_ch.pixel_address <= r.addr;
        pixel_ch.template_bits <= r.bits;
        pixel_ch.red           <= r.red;
        pixel_ch.green         <= r.green;
        pixel_ch.blue          <= r.blue;
        pixel_ch.last_pixel    <= r.last;
        do
            @(posedge clk);
        while (!pixel_ch.ready);
        requests_sent++;
        gap = pacing_on ? pick_gap() : 0;
        if (gap > 0)
        begin
            @(negedge clk);
            pixel_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // A load carries junk in its color fields; they must be ignored.
    task automatic load_template(input logic [ADDR_W-1:0] addr,
                                 input logic [TEMPLATE_W-1:0] bits,
                                 input logic last);
        pixel_req_t r;
        r.kind  = KIND_LOAD;
        r.addr  = addr;
        r.bits  = bits;
        r.red   = COLOR_W'($urandom);
        r.green = COLOR_W'($urandom);
        r.blue  = COLOR_W'($urandom);
        r.last  = last;
        loaded_addrs.push_back(addr);
        issue_request(r);
    endtask

    // A classify request carries junk template bits; they must be ignored.
    task automatic classify_pixel(input logic [ADDR_W-1:0] addr,
                                  input logic [COLOR_W-1:0] red,
                                  input logic [COLOR_W-1:0] green,
                                  input logic [COLOR_W-1:0] blue,
                                  input logic last);
        pixel_req_t r;
        r.kind  = KIND_CLASSIFY;
        r.addr  = addr;
        r.bits  = TEMPLATE_W'($urandom);
        r.red   = red;
        r.green = green;
        r.blue  = blue;
        r.last  = last;
        issue_request(r);
    endtask

    task automatic classify_random(input logic [ADDR_W-1:0] addr, input logic last);
        logic [COLOR_W-1:0] r;
        logic [COLOR_W-1:0] g;
        logic [COLOR_W-1:0] b;
        pick_color(keeper.threshold, r, g, b);
        classify_pixel(addr, r, g, b, last);
    endtask

    function automatic logic [ADDR_W-1:0] pick_loaded();
        return loaded_addrs[$urandom_range(0, loaded_addrs.size() - 1)];
    endfunction

    // Stops sending and waits for every pending verdict. Requests that cause
    // no verdict may still be in flight, so the settle argument extends the
    // wait after the last one arrives.
    task automatic drain_verdicts(input int settle);
        @(negedge clk);
        pixel_ch.valid <= 1'b0;
        while (keeper.pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    // Only called while the block is idle, so the predictor can switch to
    // the new threshold at once.
    task automatic write_threshold(input logic [THRESH_W-1:0] value);
        @(negedge clk);
        thresh_we    <= 1'b1;
        thresh_wdata <= value;
        @(negedge clk);
        thresh_we    <= 1'b0;
        keeper.threshold = value;
    endtask

    // Random phase. Most of the traffic is well-formed frames: load a run of
    // template words, then classify every pixel of the run with the last one
    // marked. Mixed in are frames over words loaded earlier, stray loads
    // (some with the last flag set, which must not end a frame) and partial
    // frames whose tallies carry into the next frame. The phase always ends
    // on a last pixel so the tallies are clear before the next threshold.
    task automatic run_random_phase(input bit hold_once);
        int start;
        int roll;
        int n;
        logic [ADDR_W-1:0] base;
        bit held;
        start = requests_sent;
        held = 1'b0;
        while (requests_sent - start < PHASE_REQUESTS)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 70)
            begin
                n = ($urandom_range(0, 99) < 90) ? $urandom_range(1, 10)
                                                 : $urandom_range(20, 48);
                base = ADDR_W'($urandom);
                for (int i = 0; i < n; i++)
                    load_template(base + ADDR_W'(i), pick_word(),
                                  $urandom_range(0, 7) == 0);
                for (int i = 0; i < n; i++)
                    classify_random(base + ADDR_W'(i), i == n - 1);
            end
            else if (roll < 82)
            begin
                n = $urandom_range(1, 8);
                for (int i = 0; i < n; i++)
                    classify_random(pick_loaded(), i == n - 1);
            end
            else if (roll < 92)
            begin
                n = $urandom_range(1, 3);
                for (int i = 0; i < n; i++)
                    load_template(ADDR_W'($urandom), TEMPLATE_W'($urandom),
                                  1'($urandom));
            end
            else
            begin
                n = $urandom_range(1, 4);
                for (int i = 0; i < n; i++)
                    classify_random(pick_loaded(), 1'b0);
            end
            // Once, hold the sender until every verdict so far has come back.
            if (hold_once && !held && requests_sent - start > PHASE_REQUESTS / 2)
            begin
                drain_verdicts(0);
                held = 1'b1;
            end
        end
        classify_random(pick_loaded(), 1'b1);
        drain_verdicts(SETTLE_CYCLES);
    endtask

    // Result side: ready is redecided at every falling edge, with stalls of
    // random length while pacing is on.
    initial
    begin
        int stall_left;
        stall_left = 0;
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                result_ch.ready <= 1'b0;
                stall_left--;
            end
            else if (pacing_on && $urandom_range(0, 3) == 0)
            begin
                stall_left = pick_gap();
                result_ch.ready <= (stall_left == 0);
            end
            else
            begin
                result_ch.ready <= 1'b1;
            end
        end
    end

    // Both channels are sampled at the rising edge, where the handshake
    // counts. A verdict can never come in the same cycle as the last pixel
    // that causes it, so the order of the two checks does not matter.
    always @(posedge clk)
    begin
        pixel_req_t seen;
        if (rst_n)
        begin
            if (result_ch.valid && result_ch.ready)
                keeper.check_result(result_ch.best_class, result_ch.mismatch_count);
            if (pixel_ch.valid && pixel_ch.ready)
            begin
                seen.kind  = pixel_ch.kind;
                seen.addr  = pixel_ch.pixel_address;
                seen.bits  = pixel_ch.template_bits;
                seen.red   = pixel_ch.red;
                seen.green = pixel_ch.green;
                seen.blue  = pixel_ch.blue;
                seen.last  = pixel_ch.last_pixel;
                keeper.note_request(seen);
            end
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial
    begin
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[%0t] timeout after %0d cycles", $realtime, CYCLE_LIMIT);
        $display("Mismatches found");
        $finish;
    end

    initial
    begin
        logic [THRESH_W-1:0] phase_thresh [6];
        rst_n                  = 1'b0;
        thresh_we              = 1'b0;
        thresh_wdata           = '0;
        pixel_ch.valid         = 1'b0;
        pixel_ch.kind          = KIND_LOAD;
        pixel_ch.pixel_address = '0;
        pixel_ch.template_bits = '0;
        pixel_ch.red           = '0;
        pixel_ch.green         = '0;
        pixel_ch.blue          = '0;
        pixel_ch.last_pixel    = 1'b0;
        pacing_on              = 1'b0;
        requests_sent          = 0;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part, at the reset threshold of 500. Words at both ends of
        // the address range, alternating bit patterns, and a load with the
        // last flag set, which must not produce a verdict.
        load_template(16'h0000, 10'h000, 1'b0);
        load_template(16'hFFFF, 10'h3FF, 1'b1);
        load_template(16'h0001, 10'h155, 1'b0);
        load_template(16'h0002, 10'h2AA, 1'b0);
        load_template(16'h0003, 10'h200, 1'b0);
        // Black, white, a sum exactly at the threshold and one just below.
        classify_pixel(16'h0000, 8'd0, 8'd0, 8'd0, 1'b0);
        classify_pixel(16'hFFFF, 8'd255, 8'd255, 8'd255, 1'b0);
        classify_pixel(16'h0001, 8'd200, 8'd200, 8'd100, 1'b0);
        classify_pixel(16'h0002, 8'd200, 8'd199, 8'd100, 1'b1);
        // Single-pixel frames: a full tie at zero, a full tie at one, and a
        // frame that only the highest class matches.
        classify_pixel(16'h0000, 8'd0, 8'd0, 8'd0, 1'b1);
        classify_pixel(16'h0000, 8'd255, 8'd255, 8'd255, 1'b1);
        classify_pixel(16'h0003, 8'd255, 8'd255, 8'd255, 1'b1);
        drain_verdicts(SETTLE_CYCLES);

        // A zero threshold makes every pixel white.
        write_threshold(10'd0);
        classify_pixel(16'h0000, 8'd0, 8'd0, 8'd0, 1'b1);
        classify_pixel(16'hFFFF, 8'd0, 8'd0, 8'd0, 1'b1);
        drain_verdicts(SETTLE_CYCLES);

        // At 765 only a fully saturated pixel is white.
        write_threshold(10'd765);
        classify_pixel(16'hFFFF, 8'd255, 8'd255, 8'd254, 1'b1);
        classify_pixel(16'hFFFF, 8'd255, 8'd255, 8'd255, 1'b1);
        drain_verdicts(SETTLE_CYCLES);

        // Above 765 nothing is white.
        write_threshold(10'd1023);
        classify_pixel(16'hFFFF, 8'd255, 8'd255, 8'd255, 1'b1);
        drain_verdicts(SETTLE_CYCLES);

        // Random phases, each under its own threshold. The first runs with
        // no gaps at all; the rest idle and stall on both sides.
        phase_thresh[0] = 10'd500;
        phase_thresh[1] = 10'd0;
        phase_thresh[2] = 10'd765;
        phase_thresh[3] = 10'd1023;
        phase_thresh[4] = THRESH_W'($urandom_range(0, 765));
        phase_thresh[5] = THRESH_W'($urandom);
        for (int p = 0; p < 6; p++)
        begin
            write_threshold(phase_thresh[p]);
            pacing_on = (p != 0);
            run_random_phase(p == 2);
        end

        drain_verdicts(SETTLE_CYCLES + 4);
        if (keeper.failures == 0 && keeper.pending_verdicts.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
